// ===== sv/dma_controller_least_users_allocator_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef DMA_CONTROLLER_LEAST_USERS_ALLOCATOR_ASSERT_SVH
`define DMA_CONTROLLER_LEAST_USERS_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DMALA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DMALA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dmala_pkg.sv =====
`timescale 1ns / 1ps
package dmala_pkg;

    localparam int NUM_CONTROLLERS_DEF = 4;
    localparam int DESC_REGS           = 4;

    localparam int DESC_W   = 48;
    localparam int CNT_W    = 8;
    localparam int IDX_W    = 2;
    localparam int STAT_W   = 3;
    localparam int NCTRL_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam int DIR_W  = 8;
    localparam int CAPS_W = 16;
    localparam int DEVS_W = 16;

    localparam int DESC_DIR_LSB  = 0;
    localparam int DESC_CAPS_LSB = 8;
    localparam int DESC_DEVS_LSB = 24;
    localparam int DESC_CHAN_LSB = 40;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CTRL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESC0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DESC_LAST  = 3'd4;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic start_scan;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== sv/dmala_ctrl.sv =====
`timescale 1ns / 1ps
module dmala_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  dmala_pkg::t_dp_status i_status,
    output dmala_pkg::t_dp_cmd    o_cmd
);
    import dmala_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.start_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// ===== sv/dmala_dp.sv =====
`timescale 1ns / 1ps
module dmala_dp #(
    parameter int NUM_CONTROLLERS = dmala_pkg::NUM_CONTROLLERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dmala_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmala_pkg::DESC_W-1:0]        i_cfg_data,
    input  logic                                i_op,
    input  logic [dmala_pkg::DIR_W-1:0]         i_want_dir,
    input  logic [dmala_pkg::CAPS_W-1:0]        i_want_caps,
    input  logic [dmala_pkg::DEVS_W-1:0]        i_want_devs,
    input  logic                                i_exclusive,
    input  logic [dmala_pkg::IDX_W-1:0]         i_release_index,
    input  dmala_pkg::t_dp_cmd                  i_cmd,
    output dmala_pkg::t_dp_status               o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dmala_pkg::STAT_W-1:0]        o_status_code,
    output logic [dmala_pkg::IDX_W-1:0]         o_chosen_index,
    output logic [dmala_pkg::CNT_W-1:0]         o_users_after,
    output logic                                o_first_use,
    output logic                                o_last_release
);
    import dmala_pkg::*;

    localparam int LIVE = (NUM_CONTROLLERS < DESC_REGS) ? NUM_CONTROLLERS : DESC_REGS;

    logic [NCTRL_W-1:0] r_ctrl_count;
    logic [DESC_W-1:0]  r_desc [DESC_REGS];
    logic [CNT_W-1:0]   r_counts [LIVE];

    logic               r_op;
    logic [DIR_W-1:0]   r_dir;
    logic [CAPS_W-1:0]  r_caps;
    logic [DEVS_W-1:0]  r_devs;
    logic               r_excl;
    logic [IDX_W-1:0]   r_rel;

    logic [IDX_W-1:0]   r_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_pick;
    logic [CNT_W:0]     r_best;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [IDX_W-1:0]   r_out_idx;
    logic [CNT_W-1:0]   r_out_users;
    logic               r_out_first;
    logic               r_out_last;

    logic [NCTRL_W-1:0] n_eff;
    logic [CNT_W-1:0]   users_at_idx;
    logic [DESC_W-1:0]  desc_at_idx;
    logic [DESC_W-1:0]  cfg_desc_idx;
    logic               dir_ok;
    logic               caps_ok;
    logic               devs_ok;
    logic               take;
    logic [STAT_W-1:0]  res_status;
    logic [IDX_W-1:0]   res_idx;
    logic [CNT_W-1:0]   res_users;
    logic               res_first;
    logic               res_last;
    logic               out_free;
    logic [IDX_W-1:0]   desc_wr_idx;

    assign n_eff = (r_ctrl_count > NCTRL_W'(LIVE)) ? NCTRL_W'(LIVE) : r_ctrl_count;
    assign cfg_desc_idx = '0;
    assign desc_wr_idx = IDX_W'(i_cfg_index - REG_DESC0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_count <= '0;
            for (int j = 0; j < DESC_REGS; j++) begin
                r_desc[j] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_CTRL_COUNT) begin
                r_ctrl_count <= i_cfg_data[NCTRL_W-1:0];
            end else if (i_cfg_index <= REG_DESC_LAST) begin
                r_desc[desc_wr_idx] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        users_at_idx = '0;
        for (int j = 0; j < LIVE; j++) begin
            if (r_idx == IDX_W'(j)) begin
                users_at_idx = r_counts[j];
            end
        end
    end

    assign desc_at_idx = r_desc[r_idx] | cfg_desc_idx;

    assign dir_ok  = (r_dir == '0)
                   || ((r_dir & desc_at_idx[DESC_DIR_LSB +: DIR_W]) != '0);
    assign caps_ok = (r_caps == '0)
                   || ((r_caps & desc_at_idx[DESC_CAPS_LSB +: CAPS_W]) != '0);
    assign devs_ok = (r_devs == '0)
                   || ((r_devs & desc_at_idx[DESC_DEVS_LSB +: DEVS_W]) != '0);
    assign take = dir_ok && caps_ok && devs_ok
               && (users_at_idx < desc_at_idx[DESC_CHAN_LSB +: CNT_W])
               && (!r_excl || (users_at_idx == '0))
               && ({1'b0, users_at_idx} < r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_dir  <= i_want_dir;
            r_caps <= i_want_caps;
            r_devs <= i_want_devs;
            r_excl <= i_exclusive;
            r_rel  <= i_release_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_pick  <= '0;
            r_best  <= {1'b1, {CNT_W{1'b0}}};
        end else if (i_cmd.load) begin
            r_idx   <= (i_op == OP_RELEASE) ? i_release_index : '0;
            r_found <= 1'b0;
            r_pick  <= '0;
            r_best  <= {1'b1, {CNT_W{1'b0}}};
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (take) begin
                r_found <= 1'b1;
                r_pick  <= r_idx;
                r_best  <= {1'b0, users_at_idx};
            end
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_idx    = '0;
        res_users  = '0;
        res_first  = 1'b0;
        res_last   = 1'b0;
        if (r_op == OP_RELEASE) begin
            if ({1'b0, r_rel} >= n_eff) begin
                res_status = ST_BAD_INDEX;
            end else if (users_at_idx == '0) begin
                res_status = ST_UNUSED;
            end else begin
                res_idx   = r_rel;
                res_users = users_at_idx - CNT_W'(1);
                res_last  = (users_at_idx == CNT_W'(1));
            end
        end else begin
            if (n_eff == '0) begin
                res_status = ST_NONE;
            end else if (!r_found) begin
                res_status = ST_NO_MATCH;
            end else begin
                res_idx   = r_pick;
                res_users = r_best[CNT_W-1:0] + CNT_W'(1);
                res_first = (r_best == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LIVE; j++) begin
                r_counts[j] <= '0;
            end
        end else if (i_cmd.commit && (res_status == ST_OK)) begin
            for (int j = 0; j < LIVE; j++) begin
                if (res_idx == IDX_W'(j)) begin
                    r_counts[j] <= res_users;
                end
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= res_status;
            r_out_idx    <= res_idx;
            r_out_users  <= res_users;
            r_out_first  <= res_first;
            r_out_last   <= res_last;
        end
    end

    assign o_status.start_scan = (i_op == OP_ACQUIRE) && (n_eff != '0);
    assign o_status.scan_last  = ({1'b0, r_idx} == (n_eff - NCTRL_W'(1)));
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status_code  = r_out_status;
    assign o_chosen_index = r_out_idx;
    assign o_users_after  = r_out_users;
    assign o_first_use    = r_out_first;
    assign o_last_release = r_out_last;

endmodule

// ===== sv/dma_controller_least_users_allocator.sv =====
`timescale 1ns / 1ps
// Least-loaded DMA controller allocator. Each request item (acquire or release,
// selected by s_axis_tuser) yields exactly one result item. A release, or an
// acquire with no controller installed, goes to the result register without a
// scan; an acquire first scans the n installed controllers (at most 4), one
// descriptor per cycle through the single match-and-compare unit. The next
// request can be accepted in the cycle after the result is registered. A result
// still waiting in the output register holds the next result back from that
// register until it is taken; the next request itself can still be accepted.
module dma_controller_least_users_allocator #(
    parameter int NUM_CONTROLLERS = dmala_pkg::NUM_CONTROLLERS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dmala_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmala_pkg::DESC_W-1:0]         i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // want_dir, want_caps, want_devs, exclusive, release_index, zero fill.
    input  logic [dmala_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, chosen_index, users_after, first_use, last_release, zero fill.
    output logic [dmala_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import dmala_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [STAT_W-1:0] out_status;
    logic [IDX_W-1:0]  out_idx;
    logic [CNT_W-1:0]  out_users;
    logic              out_first;
    logic              out_last;

    dmala_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dmala_dp #(
        .NUM_CONTROLLERS (NUM_CONTROLLERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (s_axis_tuser),
        .i_want_dir      (s_axis_tdata[7:0]),
        .i_want_caps     (s_axis_tdata[23:8]),
        .i_want_devs     (s_axis_tdata[39:24]),
        .i_exclusive     (s_axis_tdata[40]),
        .i_release_index (s_axis_tdata[42:41]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_status_code   (out_status),
        .o_chosen_index  (out_idx),
        .o_users_after   (out_users),
        .o_first_use     (out_first),
        .o_last_release  (out_last)
    );

    assign m_axis_tdata = {1'b0, out_last, out_first, out_users, out_idx, out_status};

endmodule

// ===== sv/dmala_checker.sv =====
`timescale 1ns / 1ps
`include "dma_controller_least_users_allocator_assert.svh"
module dmala_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dmala_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dmala_pkg::*;

    logic [STAT_W-1:0] st;
    logic [CNT_W-1:0]  users;
    logic              first;
    logic              last;

    assign st    = m_axis_tdata[2:0];
    assign users = m_axis_tdata[12:5];
    assign first = m_axis_tdata[13];
    assign last  = m_axis_tdata[14];

    `DMALA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `DMALA_ASSERT_IMP(a_err_zero, m_axis_tvalid && (st != ST_OK),
        m_axis_tdata[14:3] == '0, "error result carries nonzero fields")

    `DMALA_ASSERT_IMP(a_first_one, m_axis_tvalid && first,
        (st == ST_OK) && (users == CNT_W'(1)) && !last, "first use without count of one")

    `DMALA_ASSERT_IMP(a_last_zero, m_axis_tvalid && last,
        (st == ST_OK) && (users == '0), "last release with nonzero count")

    `DMALA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second request accepted while one is in work")

endmodule

bind dma_controller_least_users_allocator dmala_checker u_dmala_checker (.*);
